// File: rtl/core/ufnc_pkg.sv
// Shared types, codes and helper functions of the UTF-16 newline converter.
package ufnc_pkg;

	localparam logic [1:0] FMT_CRLF = 2'd0;
	localparam logic [1:0] FMT_CR   = 2'd1;
	localparam logic [1:0] FMT_LF   = 2'd2;

	localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
	localparam logic [1:0] REG_DEST_FORMAT   = 2'd1;
	localparam logic [1:0] REG_SWAP_BYTES    = 2'd2;

	localparam logic [15:0] UNIT_CR = 16'h000D;
	localparam logic [15:0] UNIT_LF = 16'h000A;
	localparam logic [7:0]  BOM_BE_SECOND = 8'hFF;

	typedef struct packed {
		logic [7:0] in_first_byte;
		logic [7:0] in_second_byte;
		logic       in_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_first_byte;
		logic [7:0] out_second_byte;
		logic       out_last;
	} out_beat_t;

	typedef struct packed {
		logic [1:0] source_format;
		logic [1:0] dest_format;
		logic       swap_bytes;
	} cfg_t;

	// One queue entry: one or two byte pairs in output order, ready to send.
	typedef struct packed {
		logic        two;
		logic [15:0] pair0;
		logic [15:0] pair1;
		logic        last;
	} cmd_t;

	// Handshake between the front and the queue.
	typedef struct packed {
		logic push;
		cmd_t cmd;
	} push_t;

	function automatic logic [1:0] clamp_fmt(input logic [1:0] f);
		return (f == 2'd3) ? FMT_LF : f;
	endfunction

	function automatic logic [15:0] newline_of(input logic [1:0] f);
		return (f == FMT_CR) ? UNIT_CR : UNIT_LF;
	endfunction

endpackage

// File: rtl/core/utf16_newline_converter.sv
// Top level of the UTF-16 newline converter: registers, front end, queue, back end.
//
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_stall  | in_data (in_beat_t)
//  out     | output    | out_valid / out_stall| out_data (out_beat_t)
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One input beat is taken per cycle while the command queue has room.
// A unit that expands to CR LF leaves the output register as two beats, so a
// long run of such units fills the queue and holds the input back.
// The output register holds its beat while out_stall is high; the queue
// absorbs the difference until it fills and in_stall rises.
// Reset clears the byte order, held CR, queue and output valid; formats reset to LF.
module utf16_newline_converter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [1:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  ufnc_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ufnc_pkg::out_beat_t out_data
);

	ufnc_pkg::cfg_t  cfg_q;
	ufnc_pkg::push_t q_push;
	ufnc_pkg::cmd_t  head;
	logic            full;
	logic            head_valid;
	logic            pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_format <= ufnc_pkg::FMT_LF;
			cfg_q.dest_format <= ufnc_pkg::FMT_LF;
			cfg_q.swap_bytes <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ufnc_pkg::REG_SOURCE_FORMAT: cfg_q.source_format <= cfg_data;
				ufnc_pkg::REG_DEST_FORMAT: cfg_q.dest_format <= cfg_data;
				ufnc_pkg::REG_SWAP_BYTES: cfg_q.swap_bytes <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ufnc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.full     (full),
		.q_push   (q_push)
	);

	ufnc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_push     (q_push),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	ufnc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

// File: rtl/core/ufnc_front.sv
// Front end: tracks byte order and held CR, turns each unit into at most one queue command (none for a held CR).
module ufnc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  ufnc_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  ufnc_pkg::in_beat_t in_data,
	input  logic              full,
	output ufnc_pkg::push_t   q_push
);

	logic        order_known_q;
	logic        big_endian_q;
	logic        cr_pending_q;
	logic [1:0]  sf;
	logic [1:0]  df;
	logic [15:0] u;
	logic [15:0] u0;
	logic [15:0] u1;
	logic [15:0] p0;
	logic [15:0] p1;
	logic        two;
	logic        emit;
	logic        cr_next;
	logic        accept;
	logic        last;

	function automatic logic [15:0] to_pair(input logic [15:0] unit, input logic big,
		input logic swap);
		logic [15:0] pr;
		pr = big ? unit : {unit[7:0], unit[15:8]};
		return swap ? {pr[7:0], pr[15:8]} : pr;
	endfunction

	assign sf = ufnc_pkg::clamp_fmt(cfg.source_format);
	assign df = ufnc_pkg::clamp_fmt(cfg.dest_format);
	assign last = in_data.in_last;
	assign in_stall = full;
	assign accept = in_valid && !full;

	always_comb begin
		u = big_endian_q ? {in_data.in_first_byte, in_data.in_second_byte}
			: {in_data.in_second_byte, in_data.in_first_byte};
		u0 = u;
		u1 = ufnc_pkg::UNIT_LF;
		two = 1'b0;
		emit = 1'b1;
		cr_next = 1'b0;
		if (!order_known_q) begin
			u0 = u;
		end else if (cr_pending_q) begin
			if (u == ufnc_pkg::UNIT_LF) begin
				if (df == ufnc_pkg::FMT_CRLF) begin
					u0 = ufnc_pkg::UNIT_CR;
					two = 1'b1;
				end else begin
					u0 = ufnc_pkg::newline_of(df);
				end
			end else begin
				u0 = ufnc_pkg::UNIT_CR;
				if (u == ufnc_pkg::UNIT_CR && !last) begin
					cr_next = 1'b1;
				end else begin
					two = 1'b1;
					u1 = u;
				end
			end
		end else if (sf == df) begin
			u0 = u;
		end else if (sf == ufnc_pkg::FMT_CRLF) begin
			if (u == ufnc_pkg::UNIT_CR && !last) begin
				emit = 1'b0;
				cr_next = 1'b1;
			end
		end else if (df == ufnc_pkg::FMT_CRLF) begin
			if (u == ufnc_pkg::UNIT_CR || u == ufnc_pkg::UNIT_LF) begin
				u0 = ufnc_pkg::UNIT_CR;
				two = 1'b1;
			end
		end else begin
			u0 = (u == ufnc_pkg::newline_of(sf)) ? ufnc_pkg::newline_of(df) : u;
		end
	end

	// The byte order mark goes out exactly as it came in, apart from the swap.
	always_comb begin
		if (!order_known_q) begin
			p0 = to_pair({in_data.in_first_byte, in_data.in_second_byte}, 1'b1,
				cfg.swap_bytes);
		end else begin
			p0 = to_pair(u0, big_endian_q, cfg.swap_bytes);
		end
		p1 = to_pair(u1, big_endian_q, cfg.swap_bytes);
	end

	assign q_push.push = accept && emit;
	assign q_push.cmd.two = two;
	assign q_push.cmd.pair0 = p0;
	assign q_push.cmd.pair1 = p1;
	assign q_push.cmd.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_known_q <= 1'b0;
			big_endian_q <= 1'b0;
			cr_pending_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				order_known_q <= 1'b0;
				big_endian_q <= 1'b0;
				cr_pending_q <= 1'b0;
			end else begin
				order_known_q <= 1'b1;
				if (!order_known_q) begin
					big_endian_q <= (in_data.in_second_byte == ufnc_pkg::BOM_BE_SECOND);
				end
				cr_pending_q <= cr_next;
			end
		end
	end

endmodule

// File: rtl/core/ufnc_queue.sv
// Small command queue between the front end and the output sequencer.
module ufnc_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ufnc_pkg::push_t  q_push,
	output logic             full,
	output logic             head_valid,
	output ufnc_pkg::cmd_t   head,
	input  logic             pop
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ufnc_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = q_push.push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/ufnc_back.sv
// Back end: sends one or two beats per command through an output register.
module ufnc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  ufnc_pkg::cmd_t      head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output ufnc_pkg::out_beat_t out_data
);

	logic                valid_q;
	logic                sel_q;
	ufnc_pkg::out_beat_t data_q;
	logic                load;
	logic                first_of_two;
	logic [15:0]         pair;

	assign load = head_valid && (!valid_q || !out_stall);
	assign first_of_two = head.two && !sel_q;
	assign pair = sel_q ? head.pair1 : head.pair0;
	assign pop = load && !first_of_two;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q.out_first_byte <= pair[15:8];
			data_q.out_second_byte <= pair[7:0];
			data_q.out_last <= head.last && !first_of_two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q <= first_of_two;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: bench/tb_utf16_newline_converter.sv
// Self-checking testbench for the UTF-16 newline converter.
`timescale 1ns / 1ps

module tb_utf16_newline_converter;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int PHASES = 12;
	localparam int PHASE_BEATS = 90;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// Predicts the output units of the converter and checks them in order.
	class newline_scoreboard;
		logic [1:0] src_fmt;
		logic [1:0] dst_fmt;
		logic [1:0] swap_reg;
		bit order_known;
		bit big_endian;
		bit cr_held;
		ufnc_pkg::out_beat_t expected_units[$];
		ufnc_pkg::out_beat_t step_units[2];
		int step_count;
		int unsigned mismatches;
		int unsigned beats_in;
		int unsigned beats_out;
		int unsigned silent_steps;
		int unsigned streams;

		function new();
			src_fmt = ufnc_pkg::FMT_LF;
			dst_fmt = ufnc_pkg::FMT_LF;
			swap_reg = 2'd0;
			order_known = 0;
			big_endian = 0;
			cr_held = 0;
			mismatches = 0;
			beats_in = 0;
			beats_out = 0;
			silent_steps = 0;
			streams = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [1:0] val);
			case (idx)
				ufnc_pkg::REG_SOURCE_FORMAT: src_fmt = val;
				ufnc_pkg::REG_DEST_FORMAT:   dst_fmt = val;
				ufnc_pkg::REG_SWAP_BYTES:    swap_reg = {1'b0, val[0]};
				default: ;
			endcase
		endfunction

		// Format code 3 behaves as LF.
		function logic [1:0] effective_fmt(logic [1:0] f);
			return f[1] ? ufnc_pkg::FMT_LF : f;
		endfunction

		function logic [15:0] newline_unit(logic [1:0] f);
			case (f)
				ufnc_pkg::FMT_CR: return ufnc_pkg::UNIT_CR;
				default:          return ufnc_pkg::UNIT_LF;
			endcase
		endfunction

		function void emit_pair(logic [7:0] a, logic [7:0] b);
			if (swap_reg[0])
				step_units[step_count] = {b, a, 1'b0};
			else
				step_units[step_count] = {a, b, 1'b0};
			step_count++;
		endfunction

		function void emit_unit(logic [15:0] u);
			if (big_endian)
				emit_pair(u[15:8], u[7:0]);
			else
				emit_pair(u[7:0], u[15:8]);
		endfunction

		function void note_input(ufnc_pkg::in_beat_t b);
			logic [15:0] u;
			logic [1:0] sf;
			logic [1:0] df;
			sf = effective_fmt(src_fmt);
			df = effective_fmt(dst_fmt);
			step_count = 0;
			beats_in++;
			if (!order_known) begin
				big_endian = (b.in_second_byte == ufnc_pkg::BOM_BE_SECOND);
				order_known = 1;
				emit_pair(b.in_first_byte, b.in_second_byte);
			end else begin
				u = big_endian ? {b.in_first_byte, b.in_second_byte}
					: {b.in_second_byte, b.in_first_byte};
				if (cr_held) begin
					cr_held = 0;
					if (u == ufnc_pkg::UNIT_LF) begin
						if (df == ufnc_pkg::FMT_CRLF) begin
							emit_unit(ufnc_pkg::UNIT_CR);
							emit_unit(ufnc_pkg::UNIT_LF);
						end else begin
							emit_unit(newline_unit(df));
						end
					end else begin
						emit_unit(ufnc_pkg::UNIT_CR);
						if (u == ufnc_pkg::UNIT_CR && !b.in_last)
							cr_held = 1;
						else
							emit_unit(u);
					end
				end else if (sf == df) begin
					emit_unit(u);
				end else if (sf == ufnc_pkg::FMT_CRLF) begin
					if (u == ufnc_pkg::UNIT_CR && !b.in_last)
						cr_held = 1;
					else
						emit_unit(u);
				end else if (df == ufnc_pkg::FMT_CRLF) begin
					if (u == ufnc_pkg::UNIT_CR || u == ufnc_pkg::UNIT_LF) begin
						emit_unit(ufnc_pkg::UNIT_CR);
						emit_unit(ufnc_pkg::UNIT_LF);
					end else begin
						emit_unit(u);
					end
				end else begin
					emit_unit((u == newline_unit(sf)) ? newline_unit(df) : u);
				end
			end
			if (b.in_last) begin
				if (step_count > 0)
					step_units[step_count - 1].out_last = 1'b1;
				order_known = 0;
				big_endian = 0;
				cr_held = 0;
				streams++;
			end
			if (step_count == 0)
				silent_steps++;
			for (int k = 0; k < step_count; k++)
				expected_units.push_back(step_units[k]);
		endfunction

		function void check_result(ufnc_pkg::out_beat_t got);
			ufnc_pkg::out_beat_t want;
			beats_out++;
			if (expected_units.size() == 0) begin
				$error({"output beat with nothing expected: ",
					"out_first_byte %h out_second_byte %h out_last %b"},
					got.out_first_byte, got.out_second_byte, got.out_last);
				mismatches++;
				return;
			end
			want = expected_units.pop_front();
			if (got.out_first_byte !== want.out_first_byte) begin
				$error("out_first_byte: expected %h, got %h", want.out_first_byte,
					got.out_first_byte);
				mismatches++;
			end
			if (got.out_second_byte !== want.out_second_byte) begin
				$error("out_second_byte: expected %h, got %h", want.out_second_byte,
					got.out_second_byte);
				mismatches++;
			end
			if (got.out_last !== want.out_last) begin
				$error("out_last: expected %b, got %b", want.out_last, got.out_last);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_units.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [1:0] cfg_data = 2'd0;
	logic in_valid = 1'b0;
	logic in_stall;
	ufnc_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ufnc_pkg::out_beat_t out_data;

	newline_scoreboard sb;
	bit idle_on = 1'b1;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned settings_used = 0;
	bit in_stream = 0;
	bit stream_be = 0;
	bit prev_cr = 0;

	utf16_newline_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// Receiver backpressure in random bursts.
	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 19);
			out_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Presents one beat and returns at the edge that accepts it.
	task automatic send_beat(input logic [7:0] b0, input logic [7:0] b1, input logic last);
		ufnc_pkg::in_beat_t beat;
		beat = {b0, b1, last};
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(beat);
	endtask

	task automatic send_mark(input logic [7:0] b0, input logic [7:0] b1, input logic last);
		stream_be = (b1 == ufnc_pkg::BOM_BE_SECOND);
		in_stream = !last;
		prev_cr = 0;
		send_beat(b0, b1, last);
	endtask

	task automatic send_text(input logic [15:0] u, input logic last);
		in_stream = !last;
		prev_cr = (u == ufnc_pkg::UNIT_CR);
		if (stream_be)
			send_beat(u[15:8], u[7:0], last);
		else
			send_beat(u[7:0], u[15:8], last);
	endtask

	task automatic drain_output();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// A held CR leaves nothing to wait for, so allow the block to settle first.
	task automatic set_config(input logic [1:0] src, input logic [1:0] dst,
		input logic [1:0] swap);
		drain_output();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(ufnc_pkg::REG_SOURCE_FORMAT, src);
		write_reg(ufnc_pkg::REG_DEST_FORMAT, dst);
		write_reg(ufnc_pkg::REG_SWAP_BYTES, swap);
		settings_used++;
	endtask

	// Mostly well-formed text with newline-heavy content, plus odd marks and units.
	task automatic send_random_item();
		logic [15:0] u;
		int r;
		logic last;
		r = $urandom_range(0, 99);
		if (!in_stream) begin
			last = ($urandom_range(0, 39) == 0);
			if (r < 40)
				send_mark(8'hFE, 8'hFF, last);
			else if (r < 80)
				send_mark(8'hFF, 8'hFE, last);
			else
				send_mark(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), last);
		end else begin
			last = ($urandom_range(0, 29) == 0);
			if (prev_cr && $urandom_range(0, 99) < 60) begin
				u = ufnc_pkg::UNIT_LF;
			end else if (r < 30) begin
				u = ufnc_pkg::UNIT_CR;
			end else if (r < 50) begin
				u = ufnc_pkg::UNIT_LF;
			end else if (r < 58) begin
				u[15:8] = 8'($urandom_range(1, 255));
				u[7:0] = $urandom_range(0, 1) ? ufnc_pkg::UNIT_CR[7:0]
					: ufnc_pkg::UNIT_LF[7:0];
			end else if (r < 64) begin
				u[15:8] = $urandom_range(0, 1) ? ufnc_pkg::UNIT_CR[7:0]
					: ufnc_pkg::UNIT_LF[7:0];
				u[7:0] = 8'h00;
			end else begin
				u = 16'($urandom_range(0, 65535));
			end
			send_text(u, last);
		end
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers (LF to LF): little-endian mark and byte extremes.
		send_mark(8'hFF, 8'hFE, 1'b0);
		send_text(16'h0041, 1'b0);
		send_text(ufnc_pkg::UNIT_LF, 1'b0);
		send_text(16'hFFFF, 1'b0);
		send_text(16'h0000, 1'b1);

		// CRLF to CR with swapped output on a big-endian stream.
		set_config(ufnc_pkg::FMT_CRLF, ufnc_pkg::FMT_CR, 2'd1);
		send_mark(8'hFE, 8'hFF, 1'b0);
		send_text(ufnc_pkg::UNIT_CR, 1'b0);
		send_text(ufnc_pkg::UNIT_LF, 1'b0);
		send_text(ufnc_pkg::UNIT_CR, 1'b0);
		send_text(16'h0041, 1'b0);
		send_text(16'h0D00, 1'b0);
		send_text(ufnc_pkg::UNIT_CR, 1'b0);
		send_text(ufnc_pkg::UNIT_CR, 1'b0);
		send_text(ufnc_pkg::UNIT_LF, 1'b0);
		send_text(ufnc_pkg::UNIT_CR, 1'b1);

		// CR to CRLF expansion, then a stream of only a mark.
		set_config(ufnc_pkg::FMT_CR, ufnc_pkg::FMT_CRLF, 2'd2);
		write_reg(REG_UNUSED, 2'd3);
		send_mark(8'h12, 8'h34, 1'b0);
		send_text(ufnc_pkg::UNIT_CR, 1'b0);
		send_text(ufnc_pkg::UNIT_LF, 1'b0);
		send_text(16'h0041, 1'b1);
		send_mark(8'hFF, 8'hFE, 1'b1);

		// Format code 3 on both sides.
		set_config(2'd3, 2'd3, 2'd0);
		send_mark(8'hFE, 8'hFF, 1'b0);
		send_text(ufnc_pkg::UNIT_CR, 1'b1);

		// A held CR across a register change to a CRLF destination.
		set_config(ufnc_pkg::FMT_CRLF, ufnc_pkg::FMT_LF, 2'd1);
		send_mark(8'hFE, 8'hFF, 1'b0);
		send_text(ufnc_pkg::UNIT_CR, 1'b0);
		set_config(ufnc_pkg::FMT_CRLF, ufnc_pkg::FMT_CRLF, 2'd0);
		send_text(ufnc_pkg::UNIT_LF, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			idle_on <= (ph != PHASES - 1);
			case (ph)
				0: set_config(ufnc_pkg::FMT_CRLF, ufnc_pkg::FMT_LF, 2'd0);
				1: set_config(ufnc_pkg::FMT_LF, ufnc_pkg::FMT_CRLF, 2'd3);
				2: set_config(ufnc_pkg::FMT_CRLF, ufnc_pkg::FMT_CR, 2'd1);
				3: set_config(ufnc_pkg::FMT_CR, ufnc_pkg::FMT_LF, 2'd0);
				default: set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
					2'($urandom_range(0, 3)));
			endcase
			for (int i = 0; i < PHASE_BEATS; i++) begin
				if (ph == 2 && i == PHASE_BEATS / 2)
					drain_output();
				send_random_item();
			end
		end

		drain_output();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d input beats in %0d streams (%0d gave no output).",
			sb.beats_in, sb.streams, sb.silent_steps);
		$display("Used %0d settings; checked %0d output beats with %0d field mismatches.",
			settings_used, sb.beats_out, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
